@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the entry map run allocator.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/emra_pkg.sv @@
// Package for the entry map run allocator: request kinds, status codes and sizes.
// No dependencies; imported by entry_map_run_allocator_core.
package emra_pkg;

    localparam int ENTRIES_DEFAULT = 1024;
    localparam int WORD_BITS = 32;
    localparam int OFF_W = 5;
    localparam int MAP_SIZE_W = 11;
    localparam logic [MAP_SIZE_W-1:0] MAP_SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_READ = 2'd1,
        KIND_FIND = 2'd2,
        KIND_FILL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

endpackage

@@ design/entry_map_run_allocator_core.sv @@
// Entry map run allocator: a bitmap of one-bit marks kept as 32-mark words in one memory.
// out_valid rises after a set or read via ST_ACCESS, after a find once the words up to a hit
// or the last are scanned, after a fill once its words are written, and after a range error
// or empty fill, each through ST_DONE, which waits while the output is stalled. One item is
// in work at a time; the next is taken the cycle after a result is loaded. After reset a
// clearing pass zeroes all ceil(ENTRIES/32) words first. Depends on emra_pkg, assert_macros.svh.
`include "assert_macros.svh"

module entry_map_run_allocator_core
    import emra_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAP_SIZE_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [9:0]            index,
    input  logic [10:0]           end_index,
    input  logic [10:0]           run_length,
    input  logic                  mark_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  mark_out,
    output logic [9:0]            position
);

    localparam int WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = ($clog2(ENTRIES + 1) > 12) ? $clog2(ENTRIES + 1) : 12;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FIND,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [MAP_SIZE_W-1:0] map_size_reg;
    logic [AW-1:0] clr_ptr_reg;
    logic [AW-1:0] proc_reg;
    logic [AW-1:0] first_word_reg;
    logic [AW-1:0] last_word_reg;
    logic [OFF_W-1:0] lo_off_reg;
    logic [OFF_W-1:0] hi_off_reg;
    logic [CW-1:0] need_reg;
    logic [CW-1:0] c_reg;
    logic kind_set_reg;
    logic mark_reg;
    status_t res_status_reg;
    logic res_mark_reg;
    logic [9:0] res_pos_reg;
    logic out_valid_reg;
    status_t status_reg;
    logic mark_out_reg;
    logic [9:0] position_reg;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [CW-1:0] eff;
    logic [CW-1:0] eff_m1;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] end_ext;
    logic [CW-1:0] end_m1;
    logic [CW-1:0] idx_sh;
    logic [CW-1:0] end_sh;
    logic [CW-1:0] eff_sh;
    logic [AW-1:0] idx_word;
    logic [AW-1:0] end_word;
    logic [AW-1:0] eff_word;
    logic [CW-1:0] base;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] fill_mask;
    logic [WORD_BITS-1:0] match;
    logic [WORD_BITS-1:0] window;
    logic [5:0] tail_ones;
    logic [5:0] head_ones;
    logic [OFF_W-1:0] win_start;
    logic cross_hit;
    logic win_hit;
    logic [CW-1:0] found_pos;
    logic [CW-1:0] c_next;
    logic [WORD_BITS-1:0] set_word;
    logic out_free;

    always_comb
    begin
        eff = (CW'(map_size_reg) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(map_size_reg);
        eff_m1 = eff - CW'(1);
        idx_ext = CW'(index);
        end_ext = CW'(end_index);
        end_m1 = end_ext - CW'(1);
        idx_sh = idx_ext >> OFF_W;
        end_sh = end_m1 >> OFF_W;
        eff_sh = eff_m1 >> OFF_W;
        idx_word = idx_sh[AW-1:0];
        end_word = end_sh[AW-1:0];
        eff_word = eff_sh[AW-1:0];
        base = CW'(proc_reg) << OFF_W;
    end

    always_comb
    begin
        lo_mask = (proc_reg == first_word_reg) ? ({WORD_BITS{1'b1}} << lo_off_reg)
                                               : {WORD_BITS{1'b1}};
        hi_mask = (proc_reg == last_word_reg) ? ({WORD_BITS{1'b1}} >> (5'd31 - hi_off_reg))
                                              : {WORD_BITS{1'b1}};
        fill_mask = lo_mask & hi_mask;
        match = (rd_data_reg ~^ {WORD_BITS{mark_reg}}) & hi_mask;
        set_word = rd_data_reg;
        set_word[lo_off_reg] = mark_reg;
    end

    // A bit of window is set where need_reg consecutive matches start inside this word.
    always_comb
    begin
        window = {WORD_BITS{1'b1}};
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (CW'(j) < need_reg)
            begin
                window = window & (match >> j);
            end
        end
    end

    always_comb
    begin
        tail_ones = 6'd32;
        head_ones = 6'd32;
        win_start = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!match[j])
            begin
                tail_ones = 6'(j);
            end
            if (window[j])
            begin
                win_start = OFF_W'(j);
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (!match[j])
            begin
                head_ones = 6'(31 - j);
            end
        end
    end

    always_comb
    begin
        cross_hit = (c_reg != '0) && ((need_reg - c_reg) <= CW'(tail_ones));
        win_hit = (need_reg <= CW'(WORD_BITS)) && (|window);
        found_pos = cross_hit ? (base - c_reg) : (base + CW'(win_start));
        c_next = (&match) ? (c_reg + CW'(WORD_BITS)) : CW'(head_ones);
    end

    always_comb
    begin
        rd_addr = proc_reg + AW'(1);
        if (state_reg == ST_IDLE)
        begin
            rd_addr = (kind == KIND_FIND) ? '0 : idx_word;
        end
        mem_we = 1'b0;
        mem_waddr = proc_reg;
        mem_wdata = set_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_ptr_reg;
                mem_wdata = '0;
            end
            ST_ACCESS:
            begin
                mem_we = kind_set_reg;
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                mem_wdata = mark_reg ? (rd_data_reg | fill_mask) : (rd_data_reg & ~fill_mask);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            map_size_reg <= MAP_SIZE_RESET;
            clr_ptr_reg <= '0;
            proc_reg <= '0;
            first_word_reg <= '0;
            last_word_reg <= '0;
            lo_off_reg <= '0;
            hi_off_reg <= '0;
            need_reg <= CW'(1);
            c_reg <= '0;
            kind_set_reg <= 1'b0;
            mark_reg <= 1'b0;
            res_status_reg <= STATUS_OK;
            res_mark_reg <= 1'b0;
            res_pos_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= STATUS_OK;
            mark_out_reg <= 1'b0;
            position_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                map_size_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + AW'(1);
                    if (clr_ptr_reg == LAST_ADDR)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mark_reg <= mark_in;
                        kind_set_reg <= (kind == KIND_SET);
                        lo_off_reg <= index[OFF_W-1:0];
                        res_mark_reg <= 1'b0;
                        res_pos_reg <= '0;
                        c_reg <= '0;
                        need_reg <= (run_length == '0) ? CW'(1) : CW'(run_length);
                        unique case (kind)
                            KIND_SET, KIND_READ:
                            begin
                                proc_reg <= idx_word;
                                if (idx_ext >= eff)
                                begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg <= ST_ACCESS;
                                end
                            end
                            KIND_FIND:
                            begin
                                proc_reg <= '0;
                                first_word_reg <= '0;
                                last_word_reg <= eff_word;
                                hi_off_reg <= eff_m1[OFF_W-1:0];
                                if (eff == '0)
                                begin
                                    res_status_reg <= STATUS_NOT_FOUND;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg <= ST_FIND;
                                end
                            end
                            default:
                            begin
                                proc_reg <= idx_word;
                                first_word_reg <= idx_word;
                                last_word_reg <= end_word;
                                hi_off_reg <= end_m1[OFF_W-1:0];
                                priority if (end_ext > eff)
                                begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg <= ST_DONE;
                                end
                                else if (idx_ext >= end_ext)
                                begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg <= ST_DONE;
                                end
                                else
                                begin
                                    res_status_reg <= STATUS_OK;
                                    state_reg <= ST_FILL;
                                end
                            end
                        endcase
                    end
                end
                ST_ACCESS:
                begin
                    res_mark_reg <= kind_set_reg ? mark_reg : rd_data_reg[lo_off_reg];
                    state_reg <= ST_DONE;
                end
                ST_FIND:
                begin
                    priority if (cross_hit || win_hit)
                    begin
                        res_pos_reg <= found_pos[9:0];
                        state_reg <= ST_DONE;
                    end
                    else if (proc_reg == last_word_reg)
                    begin
                        res_status_reg <= STATUS_NOT_FOUND;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        proc_reg <= proc_reg + AW'(1);
                        c_reg <= c_next;
                    end
                end
                ST_FILL:
                begin
                    if (proc_reg == last_word_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        proc_reg <= proc_reg + AW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg <= res_status_reg;
                        mark_out_reg <= res_mark_reg;
                        position_reg <= res_pos_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign mark_out = mark_out_reg;
    assign position = position_reg;

    `ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second transaction taken while busy")
    `ASSERT_IMPL(a_clear_quiet, state_reg == ST_CLEAR, !out_valid, "result shown during clearing pass")
    `ASSERT_IMPL(a_write_addr, mem_we, mem_waddr <= LAST_ADDR, "map write beyond last word")
    `ASSERT_IMPL(a_run_count, state_reg == ST_FIND, c_reg < need_reg, "run count reached need unseen")

endmodule
